// ===== hdl/tfbb_pkg.sv =====
// Shared types and constants of the transformed frame bounding box block.
package tfbb_pkg;

	localparam int COEF_W  = 32;
	localparam int PIX_W   = 12;
	localparam int PROD_W  = COEF_W + PIX_W + 1;
	localparam int ACC_W   = PROD_W + 1;
	localparam int EXT_W   = 16;
	localparam int CNT_W   = $clog2(EXT_W);
	localparam int N_AXES  = 3;
	localparam int N_STEPS = 24;
	localparam int STEP_W  = $clog2(N_STEPS);
	localparam int DRAIN   = 2;
	localparam int CFG_W   = 3;

	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(N_STEPS - 1);
	localparam logic [STEP_W-1:0] LAST_DRAIN = STEP_W'(DRAIN - 1);
	localparam logic [1:0]        LAST_AXIS  = 2'(N_AXES - 1);

	localparam logic signed [COEF_W-1:0] COORD_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COORD_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef enum logic [CFG_W-1:0] {
		CFG_SPACING = 3'd0,
		CFG_X_FIRST = 3'd1,
		CFG_X_LAST  = 3'd2,
		CFG_Y_FIRST = 3'd3,
		CFG_Y_LAST  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load;
		logic              mac_en;
		logic [STEP_W-1:0] step;
		logic              div_start;
		logic [1:0]        div_axis;
		logic              clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic       vld;
		logic       term;
		logic [1:0] axis;
	} tag_t;

endpackage

// ===== hdl/transformed_frame_bounding_box.sv =====
// Top level of the transformed frame bounding box block.
//
//  Channel   Handshake                    Beat
//  frame     start in, busy out           nine transform words, frame_valid, last_frame
//  result    done strobe out              extents, origins, no_valid_frames
//  config    cfg_valid in, cfg_ready out  cfg_index, cfg_data
//
// A valid frame that is not the last runs 24 products on the one shared 32 by 13
// multiplier, then the pipeline drain. An invalid frame that is not the last leaves
// the block idle. The last frame adds three divisions on the shared divider and the
// result strobe.
// Reset clears the box and loads the default configuration. The receiver cannot stall.
module transformed_frame_bounding_box (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          xform_r00,
	input  logic signed [31:0]          xform_r01,
	input  logic signed [31:0]          xform_t0,
	input  logic signed [31:0]          xform_r10,
	input  logic signed [31:0]          xform_r11,
	input  logic signed [31:0]          xform_t1,
	input  logic signed [31:0]          xform_r20,
	input  logic signed [31:0]          xform_r21,
	input  logic signed [31:0]          xform_t2,
	input  logic                        frame_valid,
	input  logic                        last_frame,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tfbb_pkg::CFG_W-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	output logic                        done,
	output logic [15:0]                 extent_x,
	output logic [15:0]                 extent_y,
	output logic [15:0]                 extent_z,
	output logic signed [31:0]          origin_x,
	output logic signed [31:0]          origin_y,
	output logic signed [31:0]          origin_z,
	output logic                        no_valid_frames
);

	tfbb_pkg::cmd_t  cmd;
	tfbb_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	tfbb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.frame_valid (frame_valid),
		.last_frame  (last_frame),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done)
	);

	tfbb_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.xform_r00       (xform_r00),
		.xform_r01       (xform_r01),
		.xform_t0        (xform_t0),
		.xform_r10       (xform_r10),
		.xform_r11       (xform_r11),
		.xform_t1        (xform_t1),
		.xform_r20       (xform_r20),
		.xform_r21       (xform_r21),
		.xform_t2        (xform_t2),
		.frame_valid     (frame_valid),
		.extent_x        (extent_x),
		.extent_y        (extent_y),
		.extent_z        (extent_z),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.origin_z        (origin_z),
		.no_valid_frames (no_valid_frames)
	);

endmodule

// ===== hdl/tfbb_div.sv =====
// Restoring divider giving a quotient saturated to sixteen bits, one bit per cycle.
module tfbb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 dividend,
	input  logic [31:0]                 divisor,
	output logic [tfbb_pkg::EXT_W-1:0]  quotient,
	output logic                        done
);

	logic                        run_q;
	logic                        chk_q;
	logic                        done_q;
	logic [tfbb_pkg::CNT_W-1:0]  cnt_q;
	logic [tfbb_pkg::EXT_W-1:0]  dvd_q;
	logic [tfbb_pkg::EXT_W-1:0]  quo_q;
	logic [32:0]                 rem_q;
	logic [31:0]                 dvs_q;
	logic [32:0]                 rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q[31:0], dvd_q[tfbb_pkg::EXT_W-1]};
	assign fits   = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			chk_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q && chk_q) begin
			chk_q <= 1'b0;
			if (rem_q >= {1'b0, dvs_q}) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {tfbb_pkg::CNT_W{1'b1}}) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {17'b0, dividend[31:16]};
			dvd_q <= dividend[15:0];
			dvs_q <= divisor;
		end else if (run_q && chk_q) begin
			if (rem_q >= {1'b0, dvs_q}) begin
				quo_q <= '1;
			end else begin
				quo_q <= '0;
			end
		end else if (run_q) begin
			dvd_q <= {dvd_q[tfbb_pkg::EXT_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[tfbb_pkg::EXT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[tfbb_pkg::EXT_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hdl/tfbb_dp.sv =====
// Datapath: configuration registers, corner multiply-accumulate pipeline, box and extents.
module tfbb_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfbb_pkg::cmd_t              cmd,
	output tfbb_pkg::stat_t             stat,
	input  logic                        cfg_we,
	input  logic [tfbb_pkg::CFG_W-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic signed [31:0]          xform_r00,
	input  logic signed [31:0]          xform_r01,
	input  logic signed [31:0]          xform_t0,
	input  logic signed [31:0]          xform_r10,
	input  logic signed [31:0]          xform_r11,
	input  logic signed [31:0]          xform_t1,
	input  logic signed [31:0]          xform_r20,
	input  logic signed [31:0]          xform_r21,
	input  logic signed [31:0]          xform_t2,
	input  logic                        frame_valid,
	output logic [15:0]                 extent_x,
	output logic [15:0]                 extent_y,
	output logic [15:0]                 extent_z,
	output logic signed [31:0]          origin_x,
	output logic signed [31:0]          origin_y,
	output logic signed [31:0]          origin_z,
	output logic                        no_valid_frames
);

	logic [31:0]                     spacing_q;
	logic [tfbb_pkg::PIX_W-1:0]      x_first_q, x_last_q, y_first_q, y_last_q;

	logic signed [31:0]              r0_q [tfbb_pkg::N_AXES];
	logic signed [31:0]              r1_q [tfbb_pkg::N_AXES];
	logic signed [31:0]              t_q  [tfbb_pkg::N_AXES];

	logic signed [31:0]              box_min_q [tfbb_pkg::N_AXES];
	logic signed [31:0]              box_max_q [tfbb_pkg::N_AXES];
	logic                            any_valid_q;
	logic [tfbb_pkg::EXT_W-1:0]      ext_q [tfbb_pkg::N_AXES];

	tfbb_pkg::tag_t                  tag_c, tag_s1, tag_s2;
	logic signed [31:0]              coef_c;
	logic [tfbb_pkg::PIX_W-1:0]      pix_c;
	logic signed [tfbb_pkg::PROD_W-1:0] prod_c, prod_s1;
	logic signed [tfbb_pkg::ACC_W-1:0]  acc_s2;
	logic signed [31:0]              t_sel;
	logic signed [31:0]              coord_c;
	logic signed [32:0]              diff_c [tfbb_pkg::N_AXES];
	logic [32:0]                     diff_sel;
	logic                            diff_pos;
	logic [tfbb_pkg::EXT_W-1:0]      quo;
	logic                            div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 32'd32768;
			x_first_q <= 12'd0;
			x_last_q  <= 12'd819;
			y_first_q <= 12'd0;
			y_last_q  <= 12'd615;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfbb_pkg::CFG_SPACING: spacing_q <= cfg_data;
				tfbb_pkg::CFG_X_FIRST: x_first_q <= cfg_data[tfbb_pkg::PIX_W-1:0];
				tfbb_pkg::CFG_X_LAST:  x_last_q  <= cfg_data[tfbb_pkg::PIX_W-1:0];
				tfbb_pkg::CFG_Y_FIRST: y_first_q <= cfg_data[tfbb_pkg::PIX_W-1:0];
				tfbb_pkg::CFG_Y_LAST:  y_last_q  <= cfg_data[tfbb_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q[0] <= xform_r00;
			r1_q[0] <= xform_r01;
			t_q[0]  <= xform_t0;
			r0_q[1] <= xform_r10;
			r1_q[1] <= xform_r11;
			t_q[1]  <= xform_t1;
			r0_q[2] <= xform_r20;
			r1_q[2] <= xform_r21;
			t_q[2]  <= xform_t2;
		end
	end

	// Step code is axis, corner and term; the corner picks the column and row.
	always_comb begin
		tag_c.vld  = cmd.mac_en;
		tag_c.term = cmd.step[0];
		tag_c.axis = cmd.step[4:3];
		pix_c  = '0;
		coef_c = '0;
		if (tag_c.term) begin
			pix_c = cmd.step[1] ? y_last_q : y_first_q;
		end else begin
			pix_c = cmd.step[2] ? x_last_q : x_first_q;
		end
		for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
			if (tag_c.axis == 2'(a)) begin
				coef_c = tag_c.term ? r1_q[a] : r0_q[a];
			end
		end
		prod_c = coef_c * $signed({1'b0, pix_c});
	end

	always_comb begin
		t_sel = '0;
		for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
			if (tag_s1.axis == 2'(a)) begin
				t_sel = t_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_c;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (tag_s1.vld) begin
			if (tag_s1.term) begin
				acc_s2 <= acc_s2 + tfbb_pkg::ACC_W'(prod_s1);
			end else begin
				acc_s2 <= tfbb_pkg::ACC_W'(t_sel) + tfbb_pkg::ACC_W'(prod_s1);
			end
		end
	end

	always_comb begin
		if (acc_s2[tfbb_pkg::ACC_W-1:31] == '0 || acc_s2[tfbb_pkg::ACC_W-1:31] == '1) begin
			coord_c = acc_s2[31:0];
		end else if (acc_s2[tfbb_pkg::ACC_W-1]) begin
			coord_c = tfbb_pkg::COORD_MIN;
		end else begin
			coord_c = tfbb_pkg::COORD_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
				box_min_q[a] <= tfbb_pkg::COORD_MAX;
				box_max_q[a] <= tfbb_pkg::COORD_MIN;
			end
			any_valid_q <= 1'b0;
		end else if (cmd.clear) begin
			for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
				box_min_q[a] <= tfbb_pkg::COORD_MAX;
				box_max_q[a] <= tfbb_pkg::COORD_MIN;
			end
			any_valid_q <= 1'b0;
		end else begin
			if (cmd.load && frame_valid) begin
				any_valid_q <= 1'b1;
			end
			for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
				if (tag_s2.vld && tag_s2.term && tag_s2.axis == 2'(a)) begin
					if (coord_c < box_min_q[a]) begin
						box_min_q[a] <= coord_c;
					end
					if (coord_c > box_max_q[a]) begin
						box_max_q[a] <= coord_c;
					end
				end
			end
		end
	end

	always_comb begin
		diff_sel = '0;
		for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
			diff_c[a] = {box_max_q[a][31], box_max_q[a]} - {box_min_q[a][31], box_min_q[a]};
			if (cmd.div_axis == 2'(a)) begin
				diff_sel = diff_c[a];
			end
		end
		diff_pos = !diff_sel[32] && (diff_sel[31:0] != '0);
	end

	tfbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (diff_sel[31:0]),
		.divisor  (spacing_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		for (int a = 0; a < tfbb_pkg::N_AXES; a++) begin
			if (div_done && cmd.div_axis == 2'(a)) begin
				ext_q[a] <= diff_pos ? quo : '0;
			end
		end
	end

	assign stat.div_done   = div_done;
	assign extent_x        = any_valid_q ? ext_q[0] : '0;
	assign extent_y        = any_valid_q ? ext_q[1] : '0;
	assign extent_z        = any_valid_q ? ext_q[2] : '0;
	assign origin_x        = any_valid_q ? box_min_q[0] : '0;
	assign origin_y        = any_valid_q ? box_min_q[1] : '0;
	assign origin_z        = any_valid_q ? box_min_q[2] : '0;
	assign no_valid_frames = !any_valid_q;

endmodule

// ===== hdl/tfbb_ctrl.sv =====
// Controller: sequences the corner products, the pipeline drain, the divisions and the result.
module tfbb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             frame_valid,
	input  logic             last_frame,
	input  tfbb_pkg::stat_t  stat,
	output tfbb_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done
);

	tfbb_pkg::state_t             state_q, state_d;
	logic [tfbb_pkg::STEP_W-1:0]  step_q;
	logic [1:0]                   axis_q;
	logic                         last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfbb_pkg::ST_IDLE: begin
				if (start && frame_valid) begin
					state_d = tfbb_pkg::ST_MAC;
				end else if (start && last_frame) begin
					state_d = tfbb_pkg::ST_DIV_GO;
				end
			end
			tfbb_pkg::ST_MAC: begin
				if (step_q == tfbb_pkg::LAST_STEP) begin
					state_d = tfbb_pkg::ST_DRAIN;
				end
			end
			tfbb_pkg::ST_DRAIN: begin
				if (step_q == tfbb_pkg::LAST_DRAIN) begin
					state_d = last_q ? tfbb_pkg::ST_DIV_GO : tfbb_pkg::ST_IDLE;
				end
			end
			tfbb_pkg::ST_DIV_GO: state_d = tfbb_pkg::ST_DIV_WAIT;
			tfbb_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = (axis_q == tfbb_pkg::LAST_AXIS) ? tfbb_pkg::ST_EMIT
						: tfbb_pkg::ST_DIV_GO;
				end
			end
			tfbb_pkg::ST_EMIT: state_d = tfbb_pkg::ST_IDLE;
			default: state_d = tfbb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfbb_pkg::ST_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tfbb_pkg::ST_IDLE && start) begin
				last_q <= last_frame;
			end
			if (state_q != state_d) begin
				step_q <= '0;
			end else if (state_q == tfbb_pkg::ST_MAC || state_q == tfbb_pkg::ST_DRAIN) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == tfbb_pkg::ST_IDLE) begin
				axis_q <= '0;
			end else if (state_q == tfbb_pkg::ST_DIV_WAIT && stat.div_done) begin
				axis_q <= axis_q + 1'b1;
			end
		end
	end

	always_comb begin
		cmd.load      = (state_q == tfbb_pkg::ST_IDLE) && start;
		cmd.mac_en    = (state_q == tfbb_pkg::ST_MAC);
		cmd.step      = step_q;
		cmd.div_start = (state_q == tfbb_pkg::ST_DIV_GO);
		cmd.div_axis  = axis_q;
		cmd.clear     = (state_q == tfbb_pkg::ST_EMIT);
		busy          = (state_q != tfbb_pkg::ST_IDLE);
		done          = (state_q == tfbb_pkg::ST_EMIT);
	end

`ifndef SYNTH
	a_valid_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfbb_pkg::ST_IDLE && start && frame_valid)
		|=> (state_q == tfbb_pkg::ST_MAC && step_q == '0))
		else $error("A valid frame did not start the corner sequence at step zero.");
	a_emit_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfbb_pkg::ST_EMIT) |=> (state_q == tfbb_pkg::ST_IDLE))
		else $error("The result strobe lasted more than one cycle.");
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == tfbb_pkg::ST_DIV_WAIT))
		else $error("The divider finished while the controller was not waiting for it.");
	a_axis_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfbb_pkg::ST_DIV_GO) |-> (axis_q <= tfbb_pkg::LAST_AXIS))
		else $error("A division was started for an axis that does not exist.");
`endif

endmodule
